// File: rtl/core/drhp_pkg.sv
`default_nettype none
package drhp_pkg;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_PREDICT = 3'd1;
  localparam logic [2:0] CMD_CHECK   = 3'd2;
  localparam logic [2:0] CMD_LOOKUP  = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  localparam logic [7:0] REG_TICK_PERIOD = 8'd0;
  localparam logic [7:0] REG_THRESHOLD   = 8'd1;

  localparam logic [15:0] TICK_PERIOD_RST = 16'd2185;
  localparam logic [30:0] THRESHOLD_RST   = 31'd65536;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [31:0]        tick;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } item_t;

  typedef struct packed {
    logic               found;
    logic               needs_correction;
    logic [31:0]        out_tick;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
  } result_t;

  // one history slot as stored in the ring memory
  typedef struct packed {
    logic [31:0] tick;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_P_DT,
    ST_P_LATCH,
    ST_P_MLO,
    ST_P_MHI,
    ST_P_ACC,
    ST_P_FIN,
    ST_C_MUL,
    ST_C_ACC,
    ST_C_THR,
    ST_C_CMP,
    ST_L_SCAN,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// File: rtl/core/dead_reckoning_history_predictor.sv
`default_nettype none
// Dead-reckoning history predictor. Keeps a ring of HISTORY_DEPTH snapshots
// (tick, Q16.16 position and velocity) in a memory with one write and one read
// port and serves one command per item: add (no result), clear (no result),
// predict, check correction and lookup (scans the stored entries until a tick
// matches). Unused command codes are dropped with no result. All products go
// through one shared 32x32 multiplier under a small sequencer; the lookup scan
// reads one memory entry per cycle, newest first. The block takes no new item
// until the current one finishes; a finished result sits in an output register
// so the next item can be accepted while it waits.
// Queries on an empty ring return one item with all fields zero.
module dead_reckoning_history_predictor #(
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire drhp_pkg::item_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output drhp_pkg::result_t     out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [7:0]       cfg_index_i,
  input  wire logic [31:0]      cfg_data_i
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int EW = $bits(drhp_pkg::entry_t);

  // configuration
  logic [15:0] tick_period_q;
  logic [30:0] threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= drhp_pkg::TICK_PERIOD_RST;
      threshold_q   <= drhp_pkg::THRESHOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == drhp_pkg::REG_TICK_PERIOD) tick_period_q <= cfg_data_i[15:0];
      if (cfg_index_i == drhp_pkg::REG_THRESHOLD)   threshold_q   <= cfg_data_i[30:0];
    end
  end

  assign cfg_ready_o = 1'b1;

  // control state
  drhp_pkg::state_e state_q, state_d;
  logic [AW-1:0] newest_q, newest_d;
  logic [CW-1:0] filled_q, filled_d;
  logic [AW-1:0] ptr_q, ptr_d;      // lookup read pointer
  logic [CW-1:0] cnt_q, cnt_d;      // entries issued so far in lookup
  logic          pend_q, pend_d;    // read data of last issue is pending compare
  logic [1:0]    axis_q, axis_d;
  logic          out_valid_q, out_valid_d;

  // datapath
  drhp_pkg::item_t   req_q, req_d;
  drhp_pkg::result_t res_q, res_d;
  drhp_pkg::result_t out_q, out_d;
  logic [47:0]       dt_q, dt_d;
  logic [79:0]       acc_q, acc_d;
  logic [63:0]       prod_q;
  logic [31:0]       mul_a, mul_b;

  // ring memory
  logic [EW-1:0]     mem_q [HISTORY_DEPTH];
  logic [EW-1:0]     rdata_q;
  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  drhp_pkg::entry_t  wr_entry, ent;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_entry;
    rdata_q <= mem_q[rd_addr];
  end

  assign ent = drhp_pkg::entry_t'(rdata_q);

  // shared multiplier, product registered before any further use
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  // per-axis operand selection
  logic signed [31:0] ent_pos, ent_vel, req_pos;
  always_comb begin
    unique case (axis_q)
      2'd0:    begin ent_pos = ent.pos_x; ent_vel = ent.vel_x; req_pos = req_q.pos_x; end
      2'd1:    begin ent_pos = ent.pos_y; ent_vel = ent.vel_y; req_pos = req_q.pos_y; end
      default: begin ent_pos = ent.pos_z; ent_vel = ent.vel_z; req_pos = req_q.pos_z; end
    endcase
  end

  // predict helpers
  logic [31:0]        elapsed;
  logic [32:0]        vel_ext;
  logic [31:0]        vel_mag;
  logic [63:0]        disp_full;
  logic [33:0]        disp;
  logic signed [34:0] disp_s;
  logic signed [35:0] pos_sum;
  logic signed [31:0] pos_sat;

  // check helpers
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic               over_thr;

  always_comb begin
    elapsed   = (req_q.tick > ent.tick) ? (req_q.tick - ent.tick) : 32'd0;
    vel_ext   = {ent_vel[31], ent_vel};
    vel_mag   = ent_vel[31] ? 32'(-vel_ext) : ent_vel;
    disp_full = acc_q[79:16];
    // displacement magnitude limited to 2^33, far beyond any 32-bit result
    disp      = (disp_full > 64'h2_0000_0000) ? 34'h2_0000_0000 : disp_full[33:0];
    disp_s    = ent_vel[31] ? -$signed({1'b0, disp}) : $signed({1'b0, disp});
    pos_sum   = 36'(ent_pos) + 36'(disp_s);
    if (pos_sum > 36'sh0_7FFF_FFFF)       pos_sat = 32'sh7FFF_FFFF;
    else if (pos_sum < -36'sh0_8000_0000) pos_sat = 32'sh8000_0000;
    else                                  pos_sat = pos_sum[31:0];

    diff     = 33'(req_pos) - 33'(ent_pos);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    over_thr = diff_mag > {2'b00, threshold_q};
  end

  // sequencer
  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != drhp_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    newest_d    = newest_q;
    filled_d    = filled_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && !out_acc;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    dt_d        = dt_q;
    acc_d       = acc_q;
    mul_a       = '0;
    mul_b       = '0;
    wr_en       = 1'b0;
    wr_addr     = (newest_q == AW'(HISTORY_DEPTH - 1)) ? '0 : newest_q + 1'b1;
    wr_entry    = '{in_data_i.tick, in_data_i.pos_x, in_data_i.pos_y, in_data_i.pos_z,
                    in_data_i.vel_x, in_data_i.vel_y, in_data_i.vel_z};
    rd_addr     = newest_q;

    unique case (state_q)
      drhp_pkg::ST_IDLE: begin
        if (in_acc) begin
          req_d  = in_data_i;
          res_d  = '0;
          axis_d = '0;
          acc_d  = '0;
          priority if (in_data_i.cmd == drhp_pkg::CMD_ADD) begin
            wr_en    = 1'b1;
            newest_d = wr_addr;
            if (filled_q != CW'(HISTORY_DEPTH)) filled_d = filled_q + 1'b1;
          end else if (in_data_i.cmd == drhp_pkg::CMD_CLEAR) begin
            newest_d = '0;
            filled_d = '0;
          end else if (in_data_i.cmd == drhp_pkg::CMD_PREDICT ||
                       in_data_i.cmd == drhp_pkg::CMD_CHECK) begin
            state_d = (filled_q == '0) ? drhp_pkg::ST_DONE : drhp_pkg::ST_FETCH;
          end else if (in_data_i.cmd == drhp_pkg::CMD_LOOKUP) begin
            ptr_d   = newest_q;
            cnt_d   = '0;
            pend_d  = 1'b0;
            state_d = (filled_q == '0) ? drhp_pkg::ST_DONE : drhp_pkg::ST_L_SCAN;
          end else begin
            state_d = drhp_pkg::ST_IDLE;
          end
        end
      end
      drhp_pkg::ST_FETCH: begin
        state_d = (req_q.cmd == drhp_pkg::CMD_PREDICT) ? drhp_pkg::ST_P_DT
                                                        : drhp_pkg::ST_C_MUL;
      end
      // elapsed ticks times tick period
      drhp_pkg::ST_P_DT: begin
        mul_a   = elapsed;
        mul_b   = {16'd0, tick_period_q};
        state_d = drhp_pkg::ST_P_LATCH;
      end
      drhp_pkg::ST_P_LATCH: begin
        dt_d    = prod_q[47:0];
        state_d = drhp_pkg::ST_P_MLO;
      end
      drhp_pkg::ST_P_MLO: begin
        mul_a   = vel_mag;
        mul_b   = dt_q[31:0];
        state_d = drhp_pkg::ST_P_MHI;
      end
      drhp_pkg::ST_P_MHI: begin
        acc_d   = 80'(prod_q);
        mul_a   = vel_mag;
        mul_b   = {16'd0, dt_q[47:32]};
        state_d = drhp_pkg::ST_P_ACC;
      end
      drhp_pkg::ST_P_ACC: begin
        acc_d   = acc_q + {prod_q[47:0], 32'd0};
        state_d = drhp_pkg::ST_P_FIN;
      end
      drhp_pkg::ST_P_FIN: begin
        unique case (axis_q)
          2'd0:    res_d.out_x = pos_sat;
          2'd1:    res_d.out_y = pos_sat;
          default: res_d.out_z = pos_sat[31] ? 32'sd0 : pos_sat;  // Z stays on the ground
        endcase
        if (axis_q == 2'd2) begin
          res_d.found = 1'b1;
          state_d     = drhp_pkg::ST_DONE;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = drhp_pkg::ST_P_MLO;
        end
      end
      // squared distance; an axis already past the threshold decides alone
      drhp_pkg::ST_C_MUL: begin
        if (over_thr) res_d.needs_correction = 1'b1;
        mul_a   = over_thr ? 32'd0 : diff_mag[31:0];
        mul_b   = over_thr ? 32'd0 : diff_mag[31:0];
        state_d = drhp_pkg::ST_C_ACC;
      end
      drhp_pkg::ST_C_ACC: begin
        acc_d = acc_q + 80'(prod_q);
        if (axis_q == 2'd2) begin
          state_d = drhp_pkg::ST_C_THR;
        end else begin
          axis_d  = axis_q + 1'b1;
          state_d = drhp_pkg::ST_C_MUL;
        end
      end
      drhp_pkg::ST_C_THR: begin
        mul_a   = {1'b0, threshold_q};
        mul_b   = {1'b0, threshold_q};
        state_d = drhp_pkg::ST_C_CMP;
      end
      drhp_pkg::ST_C_CMP: begin
        res_d.found = 1'b1;
        if (acc_q > 80'(prod_q)) res_d.needs_correction = 1'b1;
        state_d = drhp_pkg::ST_DONE;
      end
      // one read issued per cycle, newest first; compare in the next cycle
      drhp_pkg::ST_L_SCAN: begin
        rd_addr = ptr_q;
        if (pend_q && ent.tick == req_q.tick) begin
          res_d   = '{1'b1, 1'b0, ent.tick, ent.pos_x, ent.pos_y, ent.pos_z,
                      ent.vel_x, ent.vel_y, ent.vel_z};
          state_d = drhp_pkg::ST_DONE;
        end else if (cnt_q == filled_q) begin
          // last entry compared this cycle, nothing matched
          pend_d  = 1'b0;
          state_d = drhp_pkg::ST_DONE;
        end else begin
          pend_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          ptr_d  = (ptr_q == '0) ? AW'(HISTORY_DEPTH - 1) : ptr_q - 1'b1;
        end
      end
      drhp_pkg::ST_DONE: begin
        if (!out_valid_q || out_acc) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = drhp_pkg::ST_IDLE;
        end
      end
      default: state_d = drhp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drhp_pkg::ST_IDLE;
      newest_q    <= '0;
      filled_q    <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      newest_q    <= newest_d;
      filled_q    <= filled_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
    dt_q  <= dt_d;
    acc_q <= acc_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CW'(HISTORY_DEPTH))
    else $error("fill count beyond depth");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == drhp_pkg::ST_DONE))
    else $error("result raised outside done");

  a_add_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.cmd == drhp_pkg::CMD_ADD && filled_q != CW'(HISTORY_DEPTH))
      |=> filled_q == $past(filled_q) + 1'b1)
    else $error("add did not grow the ring");

endmodule
`default_nettype wire

// File: tb/tb_dead_reckoning_history_predictor.sv
`default_nettype none
module tb_dead_reckoning_history_predictor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 20000;

  // Scoreboard: shadow copy of the snapshot ring plus queue of awaited results.
  class ring_scoreboard;
    drhp_pkg::entry_t  ring[DEPTH];
    int unsigned       newest;
    int unsigned       count;
    logic [15:0]       period;
    logic [30:0]       thresh;
    drhp_pkg::result_t pending[$];
    int                errors;

    function new();
      newest = 0; count = 0; errors = 0;
      period = drhp_pkg::TICK_PERIOD_RST; thresh = drhp_pkg::THRESHOLD_RST;
    endfunction

    function void set_reg(logic [7:0] idx, logic [31:0] val);
      if (idx == drhp_pkg::REG_TICK_PERIOD) period = val[15:0];
      else if (idx == drhp_pkg::REG_THRESHOLD) thresh = val[30:0];
    endfunction

    // Saturated pos + vel*dt/2^16, truncated toward zero.
    function logic signed [31:0] extrap(logic signed [31:0] pos, logic signed [31:0] vel,
                                        logic [63:0] dt);
      logic [63:0] mag, disp;
      logic signed [65:0] sum;
      mag = vel[31] ? 64'(-$signed({{32{vel[31]}}, vel})) : 64'(vel);
      disp = mag * (dt >> 16) + ((mag * (dt & 64'hFFFF)) >> 16);
      if (disp > (64'd1 << 33)) disp = 64'd1 << 33;
      sum = 66'(pos) + (vel[31] ? -$signed({2'b00, disp}) : $signed({2'b00, disp}));
      if (sum > 66'sd2147483647) return 32'sh7fffffff;
      if (sum < -66'sd2147483648) return 32'sh80000000;
      return sum[31:0];
    endfunction

    function void note_item(drhp_pkg::item_t it);
      drhp_pkg::result_t r;
      drhp_pkg::entry_t e;
      logic [31:0] elapsed;
      logic [63:0] dt, sum, m, thr;
      logic signed [33:0] d[3];
      logic far;
      logic signed [31:0] z;
      int unsigned idx;
      r = '0;
      case (it.cmd)
        drhp_pkg::CMD_ADD: begin
          newest = (newest + 1) % DEPTH;
          ring[newest] = {it.tick, it.pos_x, it.pos_y, it.pos_z, it.vel_x, it.vel_y, it.vel_z};
          if (count < DEPTH) count++;
          return;
        end
        drhp_pkg::CMD_CLEAR: begin
          newest = 0; count = 0;
          return;
        end
        drhp_pkg::CMD_PREDICT, drhp_pkg::CMD_CHECK, drhp_pkg::CMD_LOOKUP: ;
        default: return;  // unused codes are dropped
      endcase
      if (count != 0) begin
        e = ring[newest];
        if (it.cmd == drhp_pkg::CMD_PREDICT) begin
          elapsed = (it.tick > e.tick) ? it.tick - e.tick : 32'd0;
          dt = 64'(elapsed) * 64'(period);
          r.found = 1'b1;
          r.out_x = extrap(e.pos_x, e.vel_x, dt);
          r.out_y = extrap(e.pos_y, e.vel_y, dt);
          z = extrap(e.pos_z, e.vel_z, dt);
          r.out_z = z[31] ? 32'sd0 : z;
        end else if (it.cmd == drhp_pkg::CMD_CHECK) begin
          d[0] = 34'(it.pos_x) - 34'($signed(e.pos_x));
          d[1] = 34'(it.pos_y) - 34'($signed(e.pos_y));
          d[2] = 34'(it.pos_z) - 34'($signed(e.pos_z));
          thr = 64'(thresh);
          far = 1'b0; sum = 0;
          for (int k = 0; k < 3; k++) begin
            m = d[k][33] ? 64'(-d[k]) : 64'(d[k]);
            if (m > thr) far = 1'b1;
            else sum += m * m;
          end
          if (!far) far = sum > thr * thr;
          r.found = 1'b1;
          r.needs_correction = far;
        end else begin
          for (int i = 0; i < count; i++) begin
            idx = (newest + DEPTH - i) % DEPTH;
            if (ring[idx].tick == it.tick) begin
              r = {1'b1, 1'b0, ring[idx].tick, ring[idx].pos_x, ring[idx].pos_y,
                   ring[idx].pos_z, ring[idx].vel_x, ring[idx].vel_y, ring[idx].vel_z};
              break;
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(drhp_pkg::result_t got);
      drhp_pkg::result_t x;
      if (pending.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got.found !== x.found) begin
        $error("found exp %0d got %0d", x.found, got.found); errors++;
      end
      if (got.needs_correction !== x.needs_correction) begin
        $error("needs_correction exp %0d got %0d", x.needs_correction, got.needs_correction);
        errors++;
      end
      if (got.out_tick !== x.out_tick) begin
        $error("out_tick exp %h got %h", x.out_tick, got.out_tick); errors++;
      end
      if (got.out_x !== x.out_x) begin
        $error("out_x exp %h got %h", x.out_x, got.out_x); errors++;
      end
      if (got.out_y !== x.out_y) begin
        $error("out_y exp %h got %h", x.out_y, got.out_y); errors++;
      end
      if (got.out_z !== x.out_z) begin
        $error("out_z exp %h got %h", x.out_z, got.out_z); errors++;
      end
      if (got.out_vel_x !== x.out_vel_x) begin
        $error("out_vel_x exp %h got %h", x.out_vel_x, got.out_vel_x); errors++;
      end
      if (got.out_vel_y !== x.out_vel_y) begin
        $error("out_vel_y exp %h got %h", x.out_vel_y, got.out_vel_y); errors++;
      end
      if (got.out_vel_z !== x.out_vel_z) begin
        $error("out_vel_z exp %h got %h", x.out_vel_z, got.out_vel_z); errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  drhp_pkg::item_t   in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b1;
  drhp_pkg::result_t out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [7:0]        cfg_index_i = '0;
  logic [31:0]       cfg_data_i = '0;

  dead_reckoning_history_predictor u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  ring_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  rx_on = 1'b0;     // receiver process runs once reset is done
  bit  hold_off = 1'b0;  // request for a long receiver stall
  // tick values already stored, so lookups mostly hit
  logic [31:0] seen_ticks[$];
  logic [31:0] next_tick = 0;

  // Sample outputs and do the bookkeeping at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL dead_reckoning_history_predictor");
        $finish;
      end
    end
  end

  // Receiver: random stall lengths per item, plus one long hold-off on request.
  initial begin : receiver
    int w;
    wait (rx_on);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Valid stays up after the handshake; the next call replaces the item or drops valid for a gap, settle() drops it.
  task automatic send_item(drhp_pkg::item_t it, bit gaps);
    int w;
    w = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19)) : 0;
    if (w > 0) begin
      in_valid_i <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drain the results, then allow for any trailing add or clear still in work.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DEPTH + 20) @(negedge clk_i);
  endtask

  function automatic logic [31:0] edge_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_pos(int sh);
    logic [31:0] v;
    v = $urandom;
    if (sh > 0) v = $signed(v) >>> sh;
    return v;
  endfunction

  function automatic drhp_pkg::item_t make_add();
    drhp_pkg::item_t it;
    int sh;
    sh = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(8, 20);
    it.cmd = drhp_pkg::CMD_ADD;
    next_tick += $urandom_range(0, 50);
    it.tick = ($urandom_range(0, 9) == 0) ? $urandom : next_tick;
    it.pos_x = rand_pos(sh); it.pos_y = rand_pos(sh); it.pos_z = rand_pos(sh);
    it.vel_x = rand_pos(sh); it.vel_y = rand_pos(sh); it.vel_z = rand_pos(sh);
    if ($urandom_range(0, 15) == 0) it.vel_x = edge_val();
    if ($urandom_range(0, 15) == 0) it.pos_z = edge_val();
    seen_ticks.push_back(it.tick);
    if (seen_ticks.size() > 100) void'(seen_ticks.pop_front());
    return it;
  endfunction

  function automatic drhp_pkg::item_t make_query();
    drhp_pkg::item_t it;
    int sel, sh;
    sh = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(4, 20);
    it = '0;
    it.vel_x = $urandom; it.vel_y = $urandom; it.vel_z = $urandom;  // ignored
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      it.cmd = drhp_pkg::CMD_PREDICT;
      it.tick = ($urandom_range(0, 7) == 0) ? $urandom : next_tick + $urandom_range(0, 3000);
    end else if (sel < 60) begin
      it.cmd = drhp_pkg::CMD_CHECK;
      it.pos_x = rand_pos(sh); it.pos_y = rand_pos(sh); it.pos_z = rand_pos(sh);
    end else if (sel < 94) begin
      it.cmd = drhp_pkg::CMD_LOOKUP;
      if (seen_ticks.size() != 0 && $urandom_range(0, 3) != 0)
        it.tick = seen_ticks[$urandom_range(0, seen_ticks.size() - 1)];
      else it.tick = $urandom;
    end else if (sel < 97) begin
      it.cmd = drhp_pkg::CMD_CLEAR;
      it.tick = $urandom;
    end else begin
      it.cmd = 3'($urandom_range(5, 7));  // unused code
      it.tick = $urandom;
    end
    return it;
  endfunction

  // Short directed set: empty-ring queries, extremes, saturation, miss and clear.
  task automatic directed();
    drhp_pkg::item_t it;
    it = '0;
    it.cmd = drhp_pkg::CMD_PREDICT; send_item(it, 0);
    it.cmd = drhp_pkg::CMD_CHECK;   send_item(it, 0);
    it.cmd = drhp_pkg::CMD_LOOKUP;  send_item(it, 0);
    it = '{drhp_pkg::CMD_ADD, 32'd0, 32'h7fffff00, 32'h80000100, 32'h00010000,
           32'h7fffffff, 32'h80000000, 32'h80000000};
    send_item(it, 0);
    it = '0; it.cmd = drhp_pkg::CMD_PREDICT; it.tick = 32'hffffffff; send_item(it, 0);
    it.tick = 32'd0; send_item(it, 0);
    it = '{drhp_pkg::CMD_CHECK, 32'hffffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff,
           '1, '1, '1};
    send_item(it, 0);
    it = '{drhp_pkg::CMD_ADD, 32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h00010000,
           32'hffff0000, 32'h00008000};
    send_item(it, 0);
    it = '0; it.cmd = drhp_pkg::CMD_PREDICT; it.tick = 32'h0; send_item(it, 0);
    it.cmd = drhp_pkg::CMD_CHECK; it.pos_x = 32'h00010000; send_item(it, 0);
    it.pos_x = 32'h00010001; send_item(it, 0);
    it = '0; it.cmd = drhp_pkg::CMD_LOOKUP; it.tick = 32'd0; send_item(it, 0);
    it.tick = 32'hffffffff; send_item(it, 0);
    it.tick = 32'h12345678; send_item(it, 0);
    it.cmd = 3'd7; send_item(it, 0);
    it.cmd = drhp_pkg::CMD_CLEAR; send_item(it, 0);
    it.cmd = drhp_pkg::CMD_LOOKUP; it.tick = 32'hffffffff; send_item(it, 0);
  endtask

  initial begin : stimulus
    int n;
    drhp_pkg::item_t it;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    rx_on = 1'b1;
    directed();
    settle();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(drhp_pkg::REG_TICK_PERIOD, 32'hffff);
          write_reg(drhp_pkg::REG_THRESHOLD, 32'h7fffffff);
        end
        1: begin
          write_reg(drhp_pkg::REG_TICK_PERIOD, 32'h0);
          write_reg(drhp_pkg::REG_THRESHOLD, 32'h0);
        end
        2: begin
          write_reg(drhp_pkg::REG_TICK_PERIOD, $urandom);
          write_reg(drhp_pkg::REG_THRESHOLD, $urandom >> 8);
        end
        3: begin
          write_reg(8'd9, $urandom);
          write_reg(drhp_pkg::REG_TICK_PERIOD, 32'h1);
        end
        default: begin
          write_reg(drhp_pkg::REG_TICK_PERIOD, drhp_pkg::TICK_PERIOD_RST);
          write_reg(drhp_pkg::REG_THRESHOLD, $urandom_range(0, 32'h00400000));
        end
      endcase
      if (phase == 1) hold_off = 1'b1;  // fill the block while the receiver sleeps
      n = 0;
      while (n < 200) begin
        it = ($urandom_range(0, 2) == 0) ? make_add() : make_query();
        if (it.cmd == drhp_pkg::CMD_CLEAR) seen_ticks.delete();
        send_item(it, phase != 1 || n > 60);
        if (it.cmd <= drhp_pkg::CMD_CLEAR) n++;
      end
      settle();
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASS dead_reckoning_history_predictor");
    else
      $display("FAIL dead_reckoning_history_predictor");
    $finish;
  end
endmodule
`default_nettype wire
